>>> hw/rtl/ssbe_pkg.sv
// ----------------------------------------------------------------------------
// ssbe_pkg: shared types and constants of the SPI slave byte engine
// Holds the action and register codes, the controller states and the
// command bundle that runs from the controller into the datapath.
// ----------------------------------------------------------------------------
package ssbe_pkg;

   localparam int unsigned ACTION_W = 2;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEVEL_W  = 6;
   localparam int unsigned CSR_IDX_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_XCHG = 2'd0,
      ACT_PUSH = 2'd1,
      ACT_POP  = 2'd2,
      ACT_NOP  = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLAVE_ENABLE = 2'd0,
      CSR_POLL_CODE    = 2'd1,
      CSR_IDLE_CODE    = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   localparam logic [BYTE_W-1:0] POLL_CODE_RESET = 8'hFF;
   localparam logic [BYTE_W-1:0] IDLE_CODE_RESET = 8'h00;
   localparam logic [BYTE_W-1:0] EMPTY_READ_BYTE = 8'hFF;
   localparam logic [BYTE_W-1:0] ZERO_BYTE       = 8'h00;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;

endpackage

>>> hw/rtl/ssbe_ifs.sv
// ----------------------------------------------------------------------------
// ssbe_ifs: channel interfaces of the SPI slave byte engine
// Request, response and register write channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface ssbe_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] data;

   modport source (output valid, output action, output data, input ready);
   modport sink   (input valid, input action, input data, output ready);
endinterface

interface ssbe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] reply_byte;
   logic [7:0] read_byte;
   logic       rx_empty;
   logic       push_accepted;
   logic       rx_dropped;
   logic [5:0] tx_level;
   logic [5:0] rx_level;

   modport source (output valid, output reply_byte, output read_byte, output rx_empty,
                   output push_accepted, output rx_dropped, output tx_level,
                   output rx_level, input ready);
   modport sink   (input valid, input reply_byte, input read_byte, input rx_empty,
                   input push_accepted, input rx_dropped, input tx_level,
                   input rx_level, output ready);
endinterface

interface ssbe_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/ssbe_ctrl.sv
// ----------------------------------------------------------------------------
// ssbe_ctrl: sequencing controller
// Accepts one beat, lets the datapath read its rings, then execute, and
// holds the result until the response beat is taken.
// ----------------------------------------------------------------------------
module ssbe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ssbe_pkg::dp_cmd_type cmd
);
   import ssbe_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/ssbe_datapath.sv
// ----------------------------------------------------------------------------
// ssbe_datapath: rings, pending byte and configuration registers
// Transmit and receive rings with registered reads, fill counters, the
// pending reply byte and the result registers.
// ----------------------------------------------------------------------------
module ssbe_datapath #(
   parameter int unsigned RING_DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ssbe_pkg::dp_cmd_type        cmd,
   input  logic [ssbe_pkg::ACTION_W-1:0]  req_action,
   input  logic [ssbe_pkg::BYTE_W-1:0]    req_data,
   input  logic                       csr_write,
   input  logic [ssbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ssbe_pkg::BYTE_W-1:0]    csr_data,
   output logic [ssbe_pkg::BYTE_W-1:0]    reply_byte,
   output logic [ssbe_pkg::BYTE_W-1:0]    read_byte,
   output logic                       rx_empty,
   output logic                       push_accepted,
   output logic                       rx_dropped,
   output logic [ssbe_pkg::LEVEL_W-1:0]   tx_level,
   output logic [ssbe_pkg::LEVEL_W-1:0]   rx_level
);
   import ssbe_pkg::*;

   localparam int unsigned AW = $clog2(RING_DEPTH);
   localparam int unsigned FW = $clog2(RING_DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(RING_DEPTH - 1);
   localparam logic [FW-1:0] FULL_FILL = FW'(RING_DEPTH);

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
      return (p == LAST_PTR) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
      return (p == '0) ? LAST_PTR : p - AW'(1);
   endfunction

   logic [BYTE_W-1:0] tx_mem_ff [RING_DEPTH];
   logic [BYTE_W-1:0] rx_mem_ff [RING_DEPTH];

   logic              enable_ff, enable_in;
   logic [BYTE_W-1:0] poll_ff, poll_in;
   logic [BYTE_W-1:0] idle_ff, idle_in;
   logic [AW-1:0]     tx_wr_ff, tx_wr_in, tx_rd_ff, tx_rd_in;
   logic [AW-1:0]     rx_wr_ff, rx_wr_in, rx_rd_ff, rx_rd_in;
   logic [FW-1:0]     tx_fill_ff, tx_fill_in, rx_fill_ff, rx_fill_in;
   logic [BYTE_W-1:0] pending_ff, pending_in;

   logic [ACTION_W-1:0] action_ff;
   logic [BYTE_W-1:0]   data_ff;
   logic [BYTE_W-1:0]   tx_q_ff, rx_q_ff;

   logic [BYTE_W-1:0]  reply_ff, reply_in, read_ff, read_in;
   logic               empty_ff, empty_in, accepted_ff, accepted_in;
   logic               dropped_ff, dropped_in;

   logic               tx_we, rx_we;
   logic [AW-1:0]      tx_waddr;
   logic [BYTE_W-1:0]  tx_wdata;
   logic               pend_live;
   logic [FW:0]        tx_used;
   logic [FW+LEVEL_W-1:0] tx_level_ext, rx_level_ext;

   always_comb begin
      enable_in = enable_ff;
      poll_in   = poll_ff;
      idle_in   = idle_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_SLAVE_ENABLE: enable_in = csr_data[0];
            CSR_POLL_CODE:    poll_in   = csr_data;
            CSR_IDLE_CODE:    idle_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   assign pend_live = (pending_ff != idle_ff);
   assign tx_used   = (FW+1)'(tx_fill_ff) + (FW+1)'(pend_live);

   always_comb begin
      tx_wr_in    = tx_wr_ff;
      tx_rd_in    = tx_rd_ff;
      tx_fill_in  = tx_fill_ff;
      rx_wr_in    = rx_wr_ff;
      rx_rd_in    = rx_rd_ff;
      rx_fill_in  = rx_fill_ff;
      pending_in  = pending_ff;
      reply_in    = ZERO_BYTE;
      read_in     = ZERO_BYTE;
      empty_in    = 1'b0;
      accepted_in = 1'b0;
      dropped_in  = 1'b0;
      tx_we       = 1'b0;
      tx_waddr    = tx_wr_ff;
      tx_wdata    = data_ff;
      rx_we       = 1'b0;
      if (cmd.execute) begin
         case (action_type'(action_ff))
            ACT_XCHG: begin
               if (enable_ff) begin
                  if (tx_fill_ff != '0 && data_ff == poll_ff) begin
                     pending_in = tx_q_ff;
                     reply_in   = tx_q_ff;
                     tx_rd_in   = ptr_next(tx_rd_ff);
                     tx_fill_in = tx_fill_ff - FW'(1);
                  end else begin
                     if (pend_live) begin
                        if (tx_fill_ff != FULL_FILL) begin
                           tx_rd_in   = ptr_prev(tx_rd_ff);
                           tx_we      = 1'b1;
                           tx_waddr   = ptr_prev(tx_rd_ff);
                           tx_wdata   = pending_ff;
                           tx_fill_in = tx_fill_ff + FW'(1);
                        end
                        pending_in = idle_ff;
                     end
                     reply_in = idle_ff;
                  end
                  if (data_ff != poll_ff) begin
                     if (rx_fill_ff != FULL_FILL) begin
                        rx_we      = 1'b1;
                        rx_wr_in   = ptr_next(rx_wr_ff);
                        rx_fill_in = rx_fill_ff + FW'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
               end
            end
            ACT_PUSH: begin
               if (tx_used < (FW+1)'(RING_DEPTH)) begin
                  tx_we       = 1'b1;
                  tx_wr_in    = ptr_next(tx_wr_ff);
                  tx_fill_in  = tx_fill_ff + FW'(1);
                  accepted_in = 1'b1;
               end
            end
            ACT_POP: begin
               if (rx_fill_ff != '0) begin
                  read_in    = rx_q_ff;
                  rx_rd_in   = ptr_next(rx_rd_ff);
                  rx_fill_in = rx_fill_ff - FW'(1);
               end else begin
                  read_in  = EMPTY_READ_BYTE;
                  empty_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         poll_ff    <= POLL_CODE_RESET;
         idle_ff    <= IDLE_CODE_RESET;
         tx_wr_ff   <= '0;
         tx_rd_ff   <= '0;
         tx_fill_ff <= '0;
         rx_wr_ff   <= '0;
         rx_rd_ff   <= '0;
         rx_fill_ff <= '0;
         pending_ff <= IDLE_CODE_RESET;
      end else begin
         enable_ff  <= enable_in;
         poll_ff    <= poll_in;
         idle_ff    <= idle_in;
         tx_wr_ff   <= tx_wr_in;
         tx_rd_ff   <= tx_rd_in;
         tx_fill_ff <= tx_fill_in;
         rx_wr_ff   <= rx_wr_in;
         rx_rd_ff   <= rx_rd_in;
         rx_fill_ff <= rx_fill_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         data_ff   <= req_data;
      end
      if (cmd.execute) begin
         reply_ff    <= reply_in;
         read_ff     <= read_in;
         empty_ff    <= empty_in;
         accepted_ff <= accepted_in;
         dropped_ff  <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem_ff[tx_waddr] <= tx_wdata;
      end
      if (cmd.capture) begin
         tx_q_ff <= tx_mem_ff[tx_rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem_ff[rx_wr_ff] <= data_ff;
      end
      if (cmd.capture) begin
         rx_q_ff <= rx_mem_ff[rx_rd_ff];
      end
   end

   assign tx_level_ext = (FW+LEVEL_W)'(tx_fill_ff);
   assign rx_level_ext = (FW+LEVEL_W)'(rx_fill_ff);

   assign reply_byte    = reply_ff;
   assign read_byte     = read_ff;
   assign rx_empty      = empty_ff;
   assign push_accepted = accepted_ff;
   assign rx_dropped    = dropped_ff;
   assign tx_level      = tx_level_ext[LEVEL_W-1:0];
   assign rx_level      = rx_level_ext[LEVEL_W-1:0];

endmodule

>>> hw/rtl/spi_slave_buffered_byte_engine.sv
// Sequencing: a request beat accepted in the idle state passes through the execute
// state, and its response is then held valid until the response beat is taken.
// Flow: a new request is taken only after the last response beat is taken, as the
// controller goes through its ring read, execute and response-hold steps in turn.
// Reset: both rings empty, no pending byte, registers at their reset codes;
// no clearing pass is needed, so the first beat is taken right after reset.
// ----------------------------------------------------------------------------
// spi_slave_buffered_byte_engine: SPI slave byte engine with byte rings
// Joins the sequencing controller and the ring datapath to the channels.
// ----------------------------------------------------------------------------
module spi_slave_buffered_byte_engine #(
   parameter int unsigned RING_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   ssbe_req_if.sink   req_ch,
   ssbe_rsp_if.source rsp_ch,
   ssbe_csr_if.sink   csr_ch
);
   import ssbe_pkg::*;

   dp_cmd_type cmd;

   assign csr_ch.ready = 1'b1;

   ssbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   ssbe_datapath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_action    (req_ch.action),
      .req_data      (req_ch.data),
      .csr_write     (csr_ch.valid),
      .csr_index     (csr_ch.index),
      .csr_data      (csr_ch.data),
      .reply_byte    (rsp_ch.reply_byte),
      .read_byte     (rsp_ch.read_byte),
      .rx_empty      (rsp_ch.rx_empty),
      .push_accepted (rsp_ch.push_accepted),
      .rx_dropped    (rsp_ch.rx_dropped),
      .tx_level      (rsp_ch.tx_level),
      .rx_level      (rsp_ch.rx_level)
   );

endmodule
